### sv/las_pkg.sv
// shared types, constants and the b3/s23 rule for the life automaton stream
`default_nettype none

package las_pkg;

	// grid limits
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;

	// position and register widths
	localparam int COL_W     = $clog2(MAX_COLUMNS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int COORD_W   = 8;

	// line store entry: bit 0 older row, bit 1 newer row
	localparam int LINE_W = 2;

	// window column: bit 0 top, bit 1 middle, bit 2 bottom
	localparam int WCOL_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);

	// register reset value
	localparam logic [CFG_W-1:0] GRID_RESET = CFG_W'(256);

	// rule constants
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// one result beat
	typedef struct packed {
		logic               next_alive;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_column;
		logic               frame_end;
	} result_t;

	// next state from neighbor count and center cell
	function automatic logic life_rule(input logic [3:0] neigh, input logic centre);
		life_rule = (neigh == BIRTH_COUNT) || (centre && (neigh == SURVIVE_COUNT));
	endfunction

endpackage

`default_nettype wire

### sv/las_line_store.sv
// two-row line store, one write and one registered read per cycle
`default_nettype none

module las_line_store
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [COL_W-1:0]  wr_addr,
	input  wire logic [LINE_W-1:0] wr_data,
	input  wire logic [COL_W-1:0]  rd_addr,
	output logic      [LINE_W-1:0] rd_data_q
);

	logic [LINE_W-1:0] mem_q [MAX_COLUMNS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### sv/las_window_cell.sv
// one column of the 3x3 window, handed to the next cell on every beat
`default_nettype none

module las_window_cell
	import las_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire logic [WCOL_W-1:0] col_in,
	output logic      [WCOL_W-1:0] col_q
);

	// take the neighbor column on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

endmodule

`default_nettype wire

### sv/life_automaton_stream.sv
// top level: streaming game of life generation step over a bordered grid
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | cell_alive
//  out     | out_valid / out_stall| next_alive, cell_row, cell_column, frame_end
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one cell per clock unless in_stall; a result registers as its bottom-right cell is accepted.
// the line store read for the next position is issued on the accepting edge, so its
// single read port keeps up with one cell per cycle.
// no clearing pass after reset: line store contents are undefined until written.
// a result and one skid entry can wait under out_stall; in_stall rises only with the skid full.
`default_nettype none

module life_automaton_stream
	import las_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 cell_alive,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      next_alive,
	output logic      [COORD_W-1:0]   cell_row,
	output logic      [COORD_W-1:0]   cell_column,
	output logic                      frame_end,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0]  grid_columns_q;
	logic [CFG_W-1:0]  grid_rows_q;
	logic [COL_W-1:0]  col_last;
	logic [ROW_W-1:0]  row_last;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;
	logic              in_accept;
	logic [COL_W-1:0]  rd_addr;
	logic [LINE_W-1:0] line_q;
	logic [WCOL_W-1:0] column_bits;
	logic [WCOL_W-1:0] wcol1_q;
	logic [WCOL_W-1:0] wcol2_q;
	logic [3:0]        neigh;
	logic              emit;
	result_t           result;
	result_t           out_q;
	result_t           skid_q;
	logic              out_valid_q;
	logic              skid_full_q;
	logic              out_take;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_RESET;
			grid_rows_q    <= GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// clamped last column and last row
	always_comb begin
		if (32'(grid_columns_q) < 32'd3) begin
			col_last = COL_W'(2);
		end else if (32'(grid_columns_q) > 32'(MAX_COLUMNS)) begin
			col_last = COL_W'(MAX_COLUMNS - 1);
		end else begin
			col_last = COL_W'(32'(grid_columns_q) - 32'd1);
		end
		if (32'(grid_rows_q) < 32'd3) begin
			row_last = ROW_W'(2);
		end else if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
			row_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			row_last = ROW_W'(32'(grid_rows_q) - 32'd1);
		end
	end

	// raster position of the next cell
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		if (col_q >= col_last) begin
			col_next = '0;
			row_next = (row_q >= row_last) ? '0 : row_q + ROW_W'(1);
		end else begin
			col_next = col_q + COL_W'(1);
			row_next = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// line store: prefetch the entry of the next position
	assign rd_addr = in_accept ? col_next : col_q;

	las_line_store u_line_store (
		.clk       (clk),
		.wr_en     (in_accept),
		.wr_addr   (col_q),
		.wr_data   ({cell_alive, line_q[1]}),
		.rd_addr   (rd_addr),
		.rd_data_q (line_q)
	);

	// window chain: newest column enters at cell 2
	assign column_bits = {cell_alive, line_q[1], line_q[0]};

	las_window_cell u_wcol2 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (in_accept),
		.col_in (column_bits),
		.col_q  (wcol2_q)
	);

	las_window_cell u_wcol1 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (in_accept),
		.col_in (wcol2_q),
		.col_q  (wcol1_q)
	);

	// neighbor count over the shifted window, center excluded
	assign neigh = 4'(wcol1_q[0]) + 4'(wcol1_q[1]) + 4'(wcol1_q[2])
		+ 4'(wcol2_q[0]) + 4'(wcol2_q[2])
		+ 4'(column_bits[0]) + 4'(column_bits[1]) + 4'(column_bits[2]);

	// interior test and result fields
	assign emit = (32'(row_q) >= 32'd2) && (row_q <= row_last)
		&& (32'(col_q) >= 32'd2) && (col_q <= col_last);

	always_comb begin
		result.next_alive  = life_rule(neigh, wcol2_q[1]);
		result.cell_row    = COORD_W'(32'(row_q) - 32'd1);
		result.cell_column = COORD_W'(32'(col_q) - 32'd1);
		result.frame_end   = (row_q == row_last) && (col_q == col_last);
	end

	// output register with one skid entry
	assign out_take = out_valid_q && !out_stall;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take) begin
				skid_full_q <= 1'b0;
			end
		end else if (in_accept && emit) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_accept && emit) begin
			if (!out_valid_q || out_take) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign next_alive  = out_q.next_alive;
	assign cell_row    = out_q.cell_row;
	assign cell_column = out_q.cell_column;
	assign frame_end   = out_q.frame_end;

endmodule

`default_nettype wire

### tb/life_automaton_stream_tb.sv
// testbench for life_automaton_stream: raster frames checked against a b3/s23 predictor
`default_nettype none

module life_automaton_stream_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import las_pkg::*;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned SHOW_LIMIT  = 10;

	// birth/survival pattern on a 5x3 grid, raster order from the msb
	localparam logic [14:0] PATTERN_5X3 = 15'b10010_10110_00000;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 cell_alive  = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 next_alive;
	logic [COORD_W-1:0]   cell_row;
	logic [COORD_W-1:0]   cell_column;
	logic                 frame_end;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;

	life_automaton_stream dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_alive  (cell_alive),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_alive  (next_alive),
		.cell_row    (cell_row),
		.cell_column (cell_column),
		.frame_end   (frame_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: two line stores, window, raster position, grid settings
	logic             line_older [MAX_COLUMNS];
	logic             line_newer [MAX_COLUMNS];
	logic [8:0]       life_window = '0;
	int unsigned      scan_row    = 0;
	int unsigned      scan_col    = 0;
	logic [CFG_W-1:0] cols_setting = GRID_RESET;
	logic [CFG_W-1:0] rows_setting = GRID_RESET;

	// expected next-generation beats and cells waiting to be sent
	result_t          next_gen_q [$];
	logic             cell_q [$];

	int unsigned      in_gap_max    = 0;
	int unsigned      out_stall_max = 0;
	int unsigned      in_gap        = 0;
	int unsigned      out_hold      = 0;
	int unsigned      fail_count    = 0;
	int unsigned      shown_count   = 0;
	int unsigned      cycle_count   = 0;
	result_t          want_beat;

	// effective grid size from a raw register value
	function automatic int unsigned fit_size(input logic [CFG_W-1:0] raw, input int unsigned hi);
		if (raw < 3) return 3;
		if (raw > hi) return hi;
		return raw;
	endfunction

	// advance one cell and queue the next state of the window center when it is interior
	function automatic void step_life(input logic cell_in);
		int unsigned cols;
		int unsigned rows;
		int unsigned neigh;
		logic        top;
		logic        mid;
		result_t     res;
		cols = fit_size(cols_setting, MAX_COLUMNS);
		rows = fit_size(rows_setting, MAX_ROWS);
		top  = 1'b0;
		mid  = 1'b0;
		if (scan_col < MAX_COLUMNS) begin
			top = line_older[scan_col];
			mid = line_newer[scan_col];
			line_older[scan_col] = mid;
			line_newer[scan_col] = cell_in;
		end
		// newest column enters at the top bits: bottom, middle, top
		life_window = {cell_in, mid, top, life_window[8:3]};
		if (scan_row >= 2 && scan_row <= rows - 1 && scan_col >= 2 && scan_col <= cols - 1) begin
			neigh = 0;
			for (int i = 0; i < 9; i++)
				if (i != 4) neigh += life_window[i];
			res.next_alive  = (neigh == BIRTH_COUNT) || (life_window[4] && neigh == SURVIVE_COUNT);
			res.cell_row    = COORD_W'(scan_row - 1);
			res.cell_column = COORD_W'(scan_col - 1);
			res.frame_end   = (scan_row == rows - 1) && (scan_col == cols - 1);
			next_gen_q.push_back(res);
		end
		if (scan_col >= cols - 1) begin
			scan_col = 0;
			scan_row = (scan_row >= rows - 1) ? 0 : scan_row + 1;
		end else begin
			scan_col = scan_col + 1;
		end
	endfunction

	// input driver: one cell per beat, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			cell_alive <= 1'b0;
			in_gap     <= 0;
		end else begin
			if (in_valid && !in_stall)
				step_life(cell_alive);
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (cell_q.size() != 0) begin
					in_valid   <= 1'b1;
					cell_alive <= cell_q.pop_front();
					in_gap     <= $urandom_range(0, in_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare each beat, then stall for a random count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (next_gen_q.size() == 0) begin
					fail_count++;
					if (shown_count < SHOW_LIMIT) begin
						shown_count++;
						$display("unexpected beat: alive %0b row %0d col %0d end %0b",
							next_alive, cell_row, cell_column, frame_end);
					end
				end else begin
					want_beat = next_gen_q.pop_front();
					if (next_alive !== want_beat.next_alive || cell_row !== want_beat.cell_row ||
					    cell_column !== want_beat.cell_column ||
					    frame_end !== want_beat.frame_end) begin
						fail_count++;
						if (shown_count < SHOW_LIMIT) begin
							shown_count++;
							$display("mismatch: expected alive %0b row %0d col %0d end %0b,",
								want_beat.next_alive, want_beat.cell_row,
								want_beat.cell_column, want_beat.frame_end,
								" got alive %0b row %0d col %0d end %0b",
								next_alive, cell_row, cell_column, frame_end);
						end
					end
				end
			end
			if (out_hold != 0) begin
				out_stall <= 1'b1;
				out_hold  <= out_hold - 1;
			end else begin
				out_stall <= 1'b0;
				if (out_valid && !out_stall)
					out_hold <= $urandom_range(0, out_stall_max);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// register write, mirrored into the predictor on the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_GRID_COLUMNS)
			cols_setting = val;
		else if (idx == REG_GRID_ROWS)
			rows_setting = val;
	endtask

	// whole random frames at the current size
	task automatic push_frames(input int unsigned frames, input int unsigned density,
			output int unsigned cells);
		cells = frames * fit_size(cols_setting, MAX_COLUMNS) * fit_size(rows_setting, MAX_ROWS);
		repeat (cells) cell_q.push_back($urandom_range(0, 99) < density);
	endtask

	// wait until every cell is sent and every beat has come back
	task automatic settle();
		while (cell_q.size() != 0 || in_valid || next_gen_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int unsigned rand_cells;
		int unsigned cells;
		int unsigned frames;
		logic [CFG_W-1:0] col_val;
		logic [CFG_W-1:0] row_val;
		rand_cells = 0;
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			line_older[i] = 1'b0;
			line_newer[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// undersized values clamp to a 3x3 grid; all live, center overcrowded
		write_reg(REG_GRID_COLUMNS, CFG_W'(0));
		write_reg(REG_GRID_ROWS, CFG_W'(2));
		repeat (9) cell_q.push_back(1'b1);
		settle();

		// birth and survival on a 5x3 grid
		write_reg(REG_GRID_COLUMNS, CFG_W'(5));
		write_reg(REG_GRID_ROWS, CFG_W'(3));
		for (int i = 14; i >= 0; i--)
			cell_q.push_back(PATTERN_5X3[i]);
		settle();

		// writes to unused indexes change nothing
		write_reg(REG_SPARE_LO, CFG_W'(9'h1FF));
		write_reg(REG_SPARE_HI, CFG_W'(9'h0AA));

		// widest grid via an oversized value, no idling
		write_reg(REG_GRID_COLUMNS, CFG_W'(511));
		write_reg(REG_GRID_ROWS, CFG_W'(3));
		push_frames(1, 50, cells);
		settle();

		// random small grids, back to back frames
		while (rand_cells < 250) begin
			in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 11;
			out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
			col_val = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 20));
			row_val = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
				: CFG_W'($urandom_range(3, 12));
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_GRID_COLUMNS, col_val);
				write_reg(REG_GRID_ROWS, row_val);
			end else begin
				write_reg(REG_GRID_ROWS, row_val);
				write_reg(REG_GRID_COLUMNS, col_val);
			end
			frames = $urandom_range(1, 3);
			push_frames(frames, $urandom_range(5, 80), cells);
			rand_cells += cells;
			settle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && next_gen_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
